/* src/sctc_pkg.sv */
// ----------------------------------------------------------------------------
// sctc_pkg
// Shared types and constants for the scratchpad CRC check and temperature
// decode block.
// ----------------------------------------------------------------------------
package sctc_pkg;

  localparam int unsigned ByteWidth = 8;
  localparam int unsigned TempWidth = 16;
  localparam int unsigned IdxWidth  = 4;

  // Scratchpad layout
  localparam logic [IdxWidth-1:0] IdxLow       = 4'd0;
  localparam logic [IdxWidth-1:0] IdxHigh      = 4'd1;
  localparam logic [IdxWidth-1:0] IdxRemain    = 4'd6;
  localparam logic [IdxWidth-1:0] IdxPerDegree = 4'd7;
  localparam logic [IdxWidth-1:0] LastIndex    = 4'd8;

  // Reflected CRC-8 polynomial
  localparam logic [ByteWidth-1:0] CrcPoly = 8'h8C;

  // Family codes
  localparam logic [ByteWidth-1:0] FamilyDirectA  = 8'h28;
  localparam logic [ByteWidth-1:0] FamilyDirectB  = 8'h22;
  localparam logic [ByteWidth-1:0] FamilyExtended = 8'h10;
  localparam logic [ByteWidth-1:0] FamilyReset    = FamilyDirectA;

  // Kelvin offsets: 4370 in 1/16 K, 17480 in 1/64 K
  localparam logic [TempWidth-1:0] DirectOffset   = 16'd4370;
  localparam logic [TempWidth-1:0] ExtendedOffset = 16'd17480;

  // Fraction divider: dividend magnitude is 16*|3*cpc - 4*rem|, below 2^14
  localparam int unsigned DivWidth = 14;
  localparam int unsigned CntWidth = $clog2(DivWidth + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_DIV,
    ST_FINISH
  } sctc_state_e;

  typedef struct packed {
    logic load;
    logic clear;
  } crc_ctrl_t;

  typedef struct packed {
    logic busy;
    logic last;
  } crc_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/sctc_crc.sv */
// ----------------------------------------------------------------------------
// sctc_crc
// Bit-serial reflected CRC-8, one data bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module sctc_crc (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sctc_pkg::crc_ctrl_t      ctrl_i,
  input  logic [7:0]               data_i,
  output logic [7:0]               acc_o,
  output sctc_pkg::crc_stat_t      stat_o
);
  import sctc_pkg::*;

  logic [ByteWidth-1:0] acc_q, acc_d;
  logic [ByteWidth-1:0] shift_q, shift_d;
  logic [2:0]           cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 fb;

  assign fb = acc_q[0] ^ shift_q[0];

  always_comb begin
    acc_d   = acc_q;
    shift_d = shift_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (ctrl_i.load) begin
      shift_d = data_i;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      acc_d   = (acc_q >> 1) ^ (fb ? CrcPoly : '0);
      shift_d = shift_q >> 1;
      cnt_d   = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign acc_o       = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.last = busy_q && (cnt_q == 3'd7);

endmodule

/* src/sctc_div.sv */
// ----------------------------------------------------------------------------
// sctc_div
// Fraction term trunc(16*(3*cpc - 4*rem) / cpc) by restoring division,
// one quotient bit per cycle, sign applied after the last quotient bit.
// ----------------------------------------------------------------------------
module sctc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [7:0]          cpc_i,
  input  logic [7:0]          rem_i,
  output logic [15:0]         quot_o,
  output sctc_pkg::div_stat_t stat_o
);
  import sctc_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [DivWidth-1:0]   dvd_q, dvd_d;
  logic [ByteWidth-1:0]  part_q, part_d;
  logic                  neg_q, neg_d;
  logic [TempWidth-1:0]  quot_q, quot_d;

  logic signed [10:0]    diff_m;
  logic [9:0]            mag_m;
  logic [ByteWidth:0]    shifted;
  logic [ByteWidth+1:0]  trial;
  logic [TempWidth-1:0]  quot_mag;

  // 64*(c-r) - 16*c == 16*(3c - 4r)
  assign diff_m = $signed({3'b000, cpc_i}) + $signed({2'b00, cpc_i, 1'b0})
                - $signed({1'b0, rem_i, 2'b00});
  assign mag_m  = diff_m[10] ? 10'(-diff_m) : diff_m[9:0];

  assign shifted  = {part_q, dvd_q[DivWidth-1]};
  assign trial    = {1'b0, shifted} - {2'b00, cpc_i};
  assign quot_mag = {{(TempWidth-DivWidth){1'b0}}, dvd_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    part_d = part_q;
    neg_d  = neg_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(DivWidth);
      dvd_d  = {mag_m, 4'b0000};
      part_d = '0;
      neg_d  = diff_m[10];
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        if (!trial[ByteWidth+1]) begin
          part_d = trial[ByteWidth-1:0];
          dvd_d  = {dvd_q[DivWidth-2:0], 1'b1};
        end else begin
          part_d = shifted[ByteWidth-1:0];
          dvd_d  = {dvd_q[DivWidth-2:0], 1'b0};
        end
        cnt_d = cnt_q - CntWidth'(1);
      end else begin
        quot_d = neg_q ? (-quot_mag) : quot_mag;
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    part_q <= part_d;
    neg_q  <= neg_d;
    quot_q <= quot_d;
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

/* src/scratchpad_crc_temperature_convert_core.sv */
// ----------------------------------------------------------------------------
// scratchpad_crc_temperature_convert_core
// Checks the CRC of a nine-byte 1-wire sensor scratchpad and turns the
// reading into a temperature in 1/64 kelvin.
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tdata[7:0]  = pad_byte
//   m_axis    out  tvalid/tready           tdata[15:0] = temperature,
//                                          tuser       = crc_ok
//   cfg       in   cfg_we_i (no wait)      cfg_wdata_i = family_code
//
// Bytes 0 to 7 are each accepted, then run through the bit-serial CRC shifter.
// Byte 8 goes from the accept to the finish step for direct and pass-through
// families and for the extended family with a zero count per degree, and for
// the extended family otherwise through 14 steps of the one-bit-per-cycle
// fraction divider, sign fix and hand-off to the finish step; the finish step
// loads the result once the output register is free. The output register lets
// the next frame enter while a result waits. Reset clears the frame position,
// the CRC and selects family 0x28.
// ----------------------------------------------------------------------------
module scratchpad_crc_temperature_convert_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config register: family_code
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // input request: [7:0] pad_byte
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // result request: [15:0] temperature
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  // result flag: [0] crc_ok
  output logic        m_axis_tuser_o
);
  import sctc_pkg::*;

  sctc_state_e state_q, state_d;

  logic [ByteWidth-1:0] family_q;
  logic [IdxWidth-1:0]  idx_q;
  logic [ByteWidth-1:0] low_q, high_q, remain_q, per_degree_q;
  logic [TempWidth-1:0] base_q, base_d;
  logic                 use_div_q;
  logic                 ok_q;

  logic                 out_valid_q;
  logic [TempWidth-1:0] out_temp_q;
  logic                 out_ok_q;

  logic                 in_accept;
  logic                 last_byte;
  logic                 is_ext;
  logic                 div_start;
  logic                 out_load;
  logic                 crc_match;
  logic [TempWidth-1:0] raw;
  logic [TempWidth-1:0] direct_sum;
  logic [TempWidth-1:0] frac_sel;

  crc_ctrl_t            crc_ctrl;
  crc_stat_t            crc_stat;
  logic [ByteWidth-1:0] crc_acc;
  div_stat_t            div_stat;
  logic [TempWidth-1:0] div_quot;

  sctc_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (s_axis_tdata_i),
    .acc_o  (crc_acc),
    .stat_o (crc_stat)
  );

  sctc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .cpc_i   (per_degree_q),
    .rem_i   (remain_q),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  // an index above 8 behaves like 8
  assign last_byte = (idx_q >= LastIndex);
  assign is_ext    = (family_q == FamilyExtended);
  assign crc_match = (crc_acc == s_axis_tdata_i);
  assign raw       = crc_match ? {high_q, low_q} : '0;
  assign direct_sum = raw + DirectOffset;

  // Base value of the conversion; the extended family adds the fraction later
  always_comb begin
    case (family_q) inside
      FamilyDirectA, FamilyDirectB: base_d = {direct_sum[TempWidth-3:0], 2'b00};
      FamilyExtended:               base_d = {raw[10:1], 6'b000000} + ExtendedOffset;
      default:                      base_d = raw;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (!last_byte) begin
            state_d = ST_CRC;
          end else if (div_start) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_CRC: begin
        if (crc_stat.last) state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (div_stat.done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    crc_ctrl.load   = in_accept && !last_byte;
    crc_ctrl.clear  = in_accept && last_byte;
    div_start       = in_accept && last_byte && is_ext && (per_degree_q != '0);
    out_load        = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready_i);
  end

  assign frac_sel = use_div_q ? div_quot : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      family_q     <= FamilyReset;
      idx_q        <= '0;
      low_q        <= '0;
      high_q       <= '0;
      remain_q     <= '0;
      per_degree_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) family_q <= cfg_wdata_i;
      if (in_accept) begin
        // capture the bytes the conversion needs, advance the frame position
        case (idx_q)
          IdxLow:       low_q        <= s_axis_tdata_i;
          IdxHigh:      high_q       <= s_axis_tdata_i;
          IdxRemain:    remain_q     <= s_axis_tdata_i;
          IdxPerDegree: per_degree_q <= s_axis_tdata_i;
          default:      ;
        endcase
        idx_q <= last_byte ? '0 : idx_q + IdxWidth'(1);
      end
      // hold the result until the sink takes it
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && last_byte) begin
      base_q    <= base_d;
      ok_q      <= crc_match;
      use_div_q <= div_start;
    end
    if (out_load) begin
      out_temp_q <= base_q + frac_sel;
      out_ok_q   <= ok_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_temp_q;
  assign m_axis_tuser_o  = out_ok_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_crc_idle_on_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_byte) |-> !crc_stat.busy)
    else $error("CRC still shifting when check byte arrives");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastIndex)
    else $error("frame position beyond check byte");

  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result raised outside finish step");

  a_div_in_div_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == ST_DIV))
    else $error("divider running outside divide step");

endmodule

/* tb/sv/scratchpad_crc_temperature_convert_core_tb.sv */
// ----------------------------------------------------------------------------
// scratchpad_crc_temperature_convert_core_tb
// Self-checking bench for the scratchpad CRC check and temperature decode.
// It feeds nine-byte scratchpad frames, most with a correct CRC and some
// with a broken one, under several family codes. A scoreboard tracks the
// frame position, the CRC and the captured bytes, predicts each temperature
// reading and compares it with what leaves the result stream.
// ----------------------------------------------------------------------------
module scratchpad_crc_temperature_convert_core_tb;
  import sctc_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned FramesPerPhase = 7;

  typedef struct packed {
    logic [TempWidth-1:0] temperature;
    logic                 crc_ok;
  } reading_t;

  // Scoreboard: mirrors the block state and holds the readings still owed.
  class reading_scoreboard;
    logic [ByteWidth-1:0] family;
    logic [ByteWidth-1:0] crc_run;
    logic [IdxWidth-1:0]  pos;
    logic [ByteWidth-1:0] low_b;
    logic [ByteWidth-1:0] high_b;
    logic [ByteWidth-1:0] remain_b;
    logic [ByteWidth-1:0] per_deg_b;
    reading_t             pending_readings[$];
    int                   errors;

    function new();
      family    = FamilyReset;
      crc_run   = '0;
      pos       = '0;
      low_b     = '0;
      high_b    = '0;
      remain_b  = '0;
      per_deg_b = '0;
      errors    = 0;
    endfunction

    // Reflected CRC-8, LSB first.
    static function logic [ByteWidth-1:0] crc8_byte(logic [ByteWidth-1:0] acc,
                                                    logic [ByteWidth-1:0] b);
      logic fb;
      for (int k = 0; k < ByteWidth; k++) begin
        fb  = acc[0] ^ b[0];
        acc = acc >> 1;
        if (fb) acc = acc ^ CrcPoly;
        b = b >> 1;
      end
      return acc;
    endfunction

    function logic [TempWidth-1:0] kelvin64(logic [TempWidth-1:0] raw);
      logic [TempWidth-1:0] t;
      int c;
      int r;
      int frac;
      if (family == FamilyDirectA || family == FamilyDirectB) begin
        t = raw + DirectOffset;
        return {t[TempWidth-3:0], 2'b00};
      end
      if (family == FamilyExtended) begin
        // arithmetic halving, then scale whole degrees to 1/64
        t    = {raw[TempWidth-1], raw[TempWidth-1:1]};
        t    = t << 6;
        frac = 0;
        if (per_deg_b != '0) begin
          c    = per_deg_b;
          r    = remain_b;
          frac = (64 * (c - r) - 16 * c) / c;
        end
        return t + 16'(frac) + ExtendedOffset;
      end
      return raw;
    endfunction

    function void note_request(logic [ByteWidth-1:0] b);
      reading_t             rd;
      logic [TempWidth-1:0] raw;
      if (pos < LastIndex) begin
        case (pos)
          IdxLow:       low_b     = b;
          IdxHigh:      high_b    = b;
          IdxRemain:    remain_b  = b;
          IdxPerDegree: per_deg_b = b;
          default: ;
        endcase
        crc_run = crc8_byte(crc_run, b);
        pos     = pos + 1'b1;
      end else begin
        rd.crc_ok      = (crc_run == b);
        raw            = rd.crc_ok ? {high_b, low_b} : '0;
        rd.temperature = kelvin64(raw);
        pending_readings.push_back(rd);
        pos     = '0;
        crc_run = '0;
      end
    endfunction

    function void check_result(logic [TempWidth-1:0] temperature, logic crc_ok);
      reading_t exp_rd;
      if (pending_readings.size() == 0) begin
        $error("unexpected result: temperature %h crc_ok %b", temperature, crc_ok);
        errors++;
        return;
      end
      exp_rd = pending_readings.pop_front();
      if (temperature !== exp_rd.temperature) begin
        $error("temperature mismatch: expected %h actual %h",
               exp_rd.temperature, temperature);
        errors++;
      end
      if (crc_ok !== exp_rd.crc_ok) begin
        $error("crc_ok mismatch: expected %b actual %b", exp_rd.crc_ok, crc_ok);
        errors++;
      end
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction
  endclass

  // DUT connections; every input is known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [7:0]  cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  // calm_phase and hold_req are shared between the stimulus and the receiver process
  bit calm_phase = 1'b0;  // no random idling on either side
  bit hold_req   = 1'b0;  // ask the receiver for one long hold-off
  bit hold_done  = 1'b0;
  int hold_left  = 0;
  int unsigned cycles = 0;

  reading_scoreboard sb = new();

  scratchpad_crc_temperature_convert_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: end the run with a failure once the cycle limit is reached.
  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Receiver: drive tready at the falling edge. Idle at random, except in a
  // calm phase; hold off for a long stretch once when asked so that the
  // output register fills and the block stalls its input.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (!calm_phase && $urandom_range(0, 99) < 6) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Monitor: check every accepted result at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Offer one byte and hold it until the block takes it. tvalid stays high
  // after the accept; the next call either reuses it or idles.
  task automatic send_byte(logic [7:0] b);
    @(negedge clk_i);
    while (!calm_phase && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(b);
  endtask

  // Send a whole scratchpad; either fix byte 8 to the CRC or force a mismatch.
  task automatic send_pad(logic [8:0][7:0] pad, bit fix_crc);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) acc = reading_scoreboard::crc8_byte(acc, pad[i]);
    if (fix_crc) pad[8] = acc;
    else if (pad[8] == acc) pad[8] = ~acc;
    for (int i = 0; i < 9; i++) send_byte(pad[i]);
  endtask

  task automatic send_random_frame();
    logic [8:0][7:0] pad;
    logic [7:0]      cpc;
    for (int i = 0; i < 9; i++) pad[i] = 8'($urandom_range(0, 255));
    // favor small and zero counts per degree for the extended conversion
    case ($urandom_range(0, 7))
      0:       cpc = '0;
      1, 2:    cpc = 8'($urandom_range(1, 16));
      default: cpc = 8'($urandom_range(0, 255));
    endcase
    pad[IdxPerDegree] = cpc;
    pad[IdxRemain]    = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, cpc));
    send_pad(pad, $urandom_range(0, 99) < 80);
  endtask

  // Drop tvalid and wait until every owed reading is back and the block idles.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_family(logic [7:0] fam);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fam;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.family = fam;
  endtask

  initial begin
    logic [7:0] fam;
    // hold reset, then release it at a falling edge
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: largest positive reading under the reset family
    send_pad({8'h00, 8'h10, 8'h0C, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h7F, 8'hFF}, 1'b1);
    // Extended family: most negative reading with zero count per degree
    set_family(FamilyExtended);
    send_pad({8'h00, 8'h00, 8'h55, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h00}, 1'b1);
    // Broken CRC, remain above count per degree
    send_pad({8'h00, 8'h10, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 8'hFF}, 1'b0);

    // Random phases, each under a family code set before it
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       fam = FamilyDirectB;
        1:       fam = FamilyExtended;
        2:       fam = 8'h00;
        3:       fam = 8'hFF;
        4:       fam = FamilyDirectA;
        5:       fam = FamilyExtended;
        default: fam = 8'($urandom_range(0, 255));
      endcase
      set_family(fam);
      calm_phase = (p == 1);
      if (p == 3) hold_req = 1'b1;
      for (int f = 0; f < FramesPerPhase; f++) send_random_frame();
    end
    calm_phase = 1'b0;

    // Wait out every owed reading and let the block settle
    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
